// ===== rtl/fct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants of the cluster table engine
// Table geometry, field widths, operation codes, register indexes and the
// controller state type.
// ----------------------------------------------------------------------------
package fct_pkg;

    // Table geometry
    localparam int ENTRIES      = 4096;
    localparam int SECTOR_BYTES = 512;
    localparam int ADDR_W       = $clog2(ENTRIES);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int CLUSTER_W = 12;
    localparam int ENTRY_W  = 32;
    localparam int VALUE_W  = 28;
    localparam int SECTOR_W = 17;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 13;
    localparam int FIRST_W  = 16;
    localparam int BYTEPOS_W = CLUSTER_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FAT_SECTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CLUSTERS   = 1'd1;

    // Reset values and limits
    localparam logic [FIRST_W-1:0] FIRST_SECTOR_RST = 16'd32;
    localparam logic [COUNT_W-1:0] TOTAL_RST        = 13'd4096;
    localparam logic [COUNT_W-1:0] HINT_RST         = 13'd2;
    localparam logic [COUNT_W-1:0] HINT_MAX         = 13'd8191;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT      = COUNT_W'(ENTRIES);

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/fct_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fct_if: valid/ready channels of the cluster table engine
// Request, response and configuration write channels, each with a source
// and a sink view.
// ----------------------------------------------------------------------------
interface fct_req_if;
    import fct_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CLUSTER_W-1:0] cluster;
    logic [ENTRY_W-1:0]   entry_value;
    modport source (output valid, kind, cluster, entry_value, input ready);
    modport sink   (input valid, kind, cluster, entry_value, output ready);
endinterface

interface fct_rsp_if;
    import fct_pkg::*;
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [SECTOR_W-1:0] table_sector;
    logic [OFFSET_W-1:0] sector_offset;
    logic [COUNT_W-1:0]  free_cluster;
    logic                found;
    modport source (output valid, read_value, table_sector, sector_offset,
                    free_cluster, found, input ready);
    modport sink   (input valid, read_value, table_sector, sector_offset,
                    free_cluster, found, output ready);
endinterface

interface fct_cfg_if;
    import fct_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fat32_cluster_table_engine_core.sv =====
`default_nettype none
// Read and write: memory read, then result and write-back, for each word.
// Find-free: the single memory read port checks one entry per cycle.
// Reset: the table memory is swept to zero, one entry per cycle, while
//   req.ready stays low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// fat32_cluster_table_engine_core: FAT32 cluster table engine
// Keeps the allocation table in one synchronous RAM; serves entry reads,
// masked entry writes and an upward scan for the next free cluster.
// ----------------------------------------------------------------------------
module fat32_cluster_table_engine_core (
    input  wire logic clk,
    input  wire logic rst_n,
    fct_req_if.sink   req,
    fct_rsp_if.source rsp,
    fct_cfg_if.sink   cfg
);
    import fct_pkg::*;

    // Table memory
    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] mem_rdata_reg;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_idx_reg;
    logic [COUNT_W-1:0]  scan_idx_reg;
    logic [COUNT_W-1:0]  chk_idx_reg;
    logic                chk_valid_reg;
    logic [COUNT_W-1:0]  lim_reg;
    logic [COUNT_W-1:0]  hint_reg;
    logic [FIRST_W-1:0]  first_sector_reg;
    logic [COUNT_W-1:0]  total_reg;

    // Captured request
    logic [KIND_W-1:0]    kind_reg;
    logic [CLUSTER_W-1:0] cluster_reg;
    logic [VALUE_W-1:0]   value_reg;

    // Output slot
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [SECTOR_W-1:0] out_sector_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [COUNT_W-1:0]  out_free_reg;
    logic                out_found_reg;

    // Datapath results
    logic                req_acc;
    logic                load_ok;
    logic                finish;
    logic                chk_hit;
    logic                scan_done;
    logic [BYTEPOS_W-1:0] bytepos;
    logic [VALUE_W-1:0]  res_value;
    logic [SECTOR_W-1:0] res_sector;
    logic [OFFSET_W-1:0] res_offset;
    logic [COUNT_W-1:0]  res_free;
    logic                res_found;
    logic [COUNT_W-1:0]  hint_next;
    logic [COUNT_W-1:0]  lim_next;

    assign req_acc   = req.valid && req.ready;
    assign load_ok   = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Scan compare: checked entry is free, or all entries below the limit are done
    assign chk_hit   = chk_valid_reg && (mem_rdata_reg[VALUE_W-1:0] == '0);
    assign scan_done = chk_hit || (scan_idx_reg >= lim_reg);
    assign lim_next  = (total_reg < ENTRY_COUNT) ? total_reg : ENTRY_COUNT;

    // Entry location on disk
    assign bytepos = {cluster_reg, 2'b00};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == ADDR_W'(ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_acc)
                    state_next = (req.kind == KIND_FIND) ? ST_SCAN : ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_done && load_ok)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory control and result word
    always_comb
    begin
        req.ready  = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = req.cluster;
        mem_we     = 1'b0;
        mem_waddr  = cluster_reg;
        mem_wdata  = {mem_rdata_reg[ENTRY_W-1:VALUE_W], value_reg};
        finish     = 1'b0;
        res_value  = '0;
        res_sector = '0;
        res_offset = '0;
        res_free   = '0;
        res_found  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                mem_re    = req.valid;
            end
            ST_ACCESS:
            begin
                finish = 1'b1;
                unique case (kind_reg)
                    KIND_READ:
                    begin
                        res_value  = mem_rdata_reg[VALUE_W-1:0];
                        res_sector = SECTOR_W'(first_sector_reg)
                                   + SECTOR_W'(bytepos / SECTOR_BYTES);
                        res_offset = OFFSET_W'(bytepos % SECTOR_BYTES);
                    end
                    KIND_WRITE:
                    begin
                        mem_we     = load_ok;
                        res_value  = value_reg;
                        res_sector = SECTOR_W'(first_sector_reg)
                                   + SECTOR_W'(bytepos / SECTOR_BYTES);
                        res_offset = OFFSET_W'(bytepos % SECTOR_BYTES);
                    end
                    default:
                    begin
                        res_value = '0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                finish    = scan_done;
                mem_re    = !scan_done;
                mem_raddr = scan_idx_reg[ADDR_W-1:0];
                res_free  = chk_hit ? chk_idx_reg : total_reg;
                res_found = chk_hit;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // Saturating hint after a scan
    assign hint_next = (res_free >= HINT_MAX) ? HINT_MAX : res_free + COUNT_W'(1);

    // Table memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            chk_valid_reg    <= 1'b0;
            hint_reg         <= HINT_RST;
            first_sector_reg <= FIRST_SECTOR_RST;
            total_reg        <= TOTAL_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the clearing sweep
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);

            // Configuration writes
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_FIRST_FAT_SECTOR: first_sector_reg <= cfg.data;
                    REG_TOTAL_CLUSTERS:   total_reg <= cfg.data[COUNT_W-1:0];
                    default:              total_reg <= total_reg;
                endcase
            end

            // Track the entry whose read data arrives next cycle
            if (req_acc)
                chk_valid_reg <= 1'b0;
            else if (state_reg == ST_SCAN)
            begin
                if (scan_done)
                begin
                    if (load_ok)
                        chk_valid_reg <= 1'b0;
                end
                else
                    chk_valid_reg <= 1'b1;
            end

            // Update the hint when a scan result leaves
            if (state_reg == ST_SCAN && scan_done && load_ok)
                hint_reg <= hint_next;

            // Output slot
            if (finish && load_ok)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg     <= req.kind;
            cluster_reg  <= req.cluster;
            value_reg    <= req.entry_value[VALUE_W-1:0];
            scan_idx_reg <= hint_reg;
            lim_reg      <= lim_next;
        end
        else if (state_reg == ST_SCAN && !scan_done)
        begin
            chk_idx_reg  <= scan_idx_reg;
            scan_idx_reg <= scan_idx_reg + COUNT_W'(1);
        end

        if (finish && load_ok)
        begin
            out_value_reg  <= res_value;
            out_sector_reg <= res_sector;
            out_offset_reg <= res_offset;
            out_free_reg   <= res_free;
            out_found_reg  <= res_found;
        end
    end

    // Drive the response channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_value    = out_value_reg;
    assign rsp.table_sector  = out_sector_reg;
    assign rsp.sector_offset = out_offset_reg;
    assign rsp.free_cluster  = out_free_reg;
    assign rsp.found         = out_found_reg;

endmodule
`default_nettype wire

// ===== bench/fct_table_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fct_table_checker: response checker for the cluster table engine
// Watches the request, response and configuration channels. Keeps its own
// copy of the allocation table, the free-scan hint and both registers, works
// out one result word per accepted request word, and compares every response
// word field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fct_table_checker
    import fct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fct_req_if        req,
    fct_rsp_if        rsp,
    fct_cfg_if        cfg,
    output int        mismatches,
    output int        outstanding
);

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [SECTOR_W-1:0] table_sector;
        logic [OFFSET_W-1:0] sector_offset;
        logic [COUNT_W-1:0]  free_cluster;
        logic                found;
    } fat_result_t;

    logic [ENTRY_W-1:0] fat_copy [ENTRIES];
    logic [COUNT_W-1:0] scan_hint;
    logic [FIRST_W-1:0] first_sector;
    logic [COUNT_W-1:0] cluster_limit;
    fat_result_t        expected_results [$];
    int                 fail_count;
    int                 result_count;

    // Count a mismatch and print one line for it
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Apply one request word to the table copy and return the result it causes
    function automatic fat_result_t run_table_op(input logic [KIND_W-1:0]    op,
                                                 input logic [CLUSTER_W-1:0] cl,
                                                 input logic [ENTRY_W-1:0]   value);
        fat_result_t          r;
        logic [BYTEPOS_W-1:0] bytepos;
        int                   idx;
        r       = '0;
        bytepos = {cl, 2'b00};
        case (op)
            KIND_READ, KIND_WRITE:
            begin
                r.table_sector  = SECTOR_W'(first_sector) + SECTOR_W'(bytepos / SECTOR_BYTES);
                r.sector_offset = OFFSET_W'(bytepos % SECTOR_BYTES);
                if (op == KIND_READ)
                begin
                    r.read_value = fat_copy[cl][VALUE_W-1:0];
                end
                else
                begin
                    // keep the reserved top nibble, replace the rest
                    r.read_value = value[VALUE_W-1:0];
                    fat_copy[cl] = {fat_copy[cl][ENTRY_W-1:VALUE_W], value[VALUE_W-1:0]};
                end
            end
            KIND_FIND:
            begin
                // scan upward from the hint; clusters past the table count as taken
                r.free_cluster = cluster_limit;
                idx            = int'(scan_hint);
                while (idx < int'(cluster_limit) && !r.found)
                begin
                    if (idx < ENTRIES && fat_copy[idx][VALUE_W-1:0] == '0)
                    begin
                        r.free_cluster = COUNT_W'(idx);
                        r.found        = 1'b1;
                    end
                    idx++;
                end
                scan_hint = (r.free_cluster >= HINT_MAX) ? HINT_MAX : r.free_cluster + 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Track register writes, retire response words, then queue new predictions
    always @(posedge clk)
    begin : watch_channels
        fat_result_t want;
        if (!rst_n)
        begin
            foreach (fat_copy[n])
                fat_copy[n] = '0;
            scan_hint     = HINT_RST;
            first_sector  = FIRST_SECTOR_RST;
            cluster_limit = TOTAL_RST;
            expected_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FIRST_FAT_SECTOR)
                    first_sector = cfg.data[FIRST_W-1:0];
                else if (cfg.index == REG_TOTAL_CLUSTERS)
                    cluster_limit = cfg.data[COUNT_W-1:0];
            end

            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("response word %0d arrived with none expected",
                                              result_count));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("word %0d read_value 0x%0h, want 0x%0h",
                                                  result_count, rsp.read_value,
                                                  want.read_value));
                    if (rsp.table_sector !== want.table_sector)
                        report_mismatch($sformatf("word %0d table_sector %0d, want %0d",
                                                  result_count, rsp.table_sector,
                                                  want.table_sector));
                    if (rsp.sector_offset !== want.sector_offset)
                        report_mismatch($sformatf("word %0d sector_offset %0d, want %0d",
                                                  result_count, rsp.sector_offset,
                                                  want.sector_offset));
                    if (rsp.free_cluster !== want.free_cluster)
                        report_mismatch($sformatf("word %0d free_cluster %0d, want %0d",
                                                  result_count, rsp.free_cluster,
                                                  want.free_cluster));
                    if (rsp.found !== want.found)
                        report_mismatch($sformatf("word %0d found %0b, want %0b",
                                                  result_count, rsp.found, want.found));
                end
                result_count++;
            end

            if (req.valid && req.ready)
                expected_results.push_back(run_table_op(req.kind, req.cluster,
                                                        req.entry_value));
        end
        outstanding <= expected_results.size();
        mismatches  <= fail_count;
    end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for the FAT32 cluster table engine
// Drives request and register words, paces the response side, and gives the
// verdict from the checker's mismatch count. A directed opening covers reset
// values, sector boundaries, masking and scan corners; random phases follow
// under several register settings and idle patterns, one with a long response
// hold-off; a closing pass fills the low end of the table so a scan runs out
// of range with nothing free.
// ----------------------------------------------------------------------------
module tb_top;
    import fct_pkg::*;

    localparam logic [KIND_W-1:0]     KIND_UNUSED      = 2'd3;
    localparam logic [CFG_DATA_W-1:0] TOTAL_PAST_TABLE = 16'h1FFF;
    localparam int                    CHOKE_CYCLES     = 400;
    localparam int                    PHASE_ITEMS      = 70;
    localparam int                    FILL_COUNT       = 48;
    localparam int                    SETTLE_CYCLES    = 8;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   stall_pct = 0;
    int   send_idle_pct = 0;
    int   cur_total = 4096;
    logic choke;
    logic squeeze_req;

    fct_req_if req_ch ();
    fct_rsp_if rsp_ch ();
    fct_cfg_if cfg_ch ();

    fat32_cluster_table_engine_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    fct_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Pace the response side; hold ready low while choked
    initial
    begin : response_pacer
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (choke)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hold off the response side for a long stretch once asked
    initial
    begin : squeeze_proc
        choke <= 1'b0;
        wait (squeeze_req === 1'b1);
        @(posedge clk);
        choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke <= 1'b0;
    end

    // Guard against a hung run
    initial
    begin : watchdog
        #300000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one request word, idling first at random, and wait for acceptance
    task automatic send_item(input logic [KIND_W-1:0]    op,
                             input logic [CLUSTER_W-1:0] cl,
                             input logic [ENTRY_W-1:0]   value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= op;
        req_ch.cluster     <= cl;
        req_ch.entry_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Write one register word
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] first,
                             input logic [CFG_DATA_W-1:0] total);
        write_reg(REG_FIRST_FAT_SECTOR, first);
        write_reg(REG_TOTAL_CLUSTERS, total);
        cur_total = int'(total[COUNT_W-1:0]);
    endtask

    // Stop offering, wait for every predicted word, then let the block settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random request word, clusters mostly near the scan range
    task automatic send_random_item();
        logic [KIND_W-1:0]    op;
        logic [CLUSTER_W-1:0] cl;
        logic [ENTRY_W-1:0]   value;
        int                   pick;
        int                   span;
        pick = $urandom_range(99);
        if (pick < 30)
            op = KIND_READ;
        else if (pick < 65)
            op = KIND_WRITE;
        else if (pick < 95)
            op = KIND_FIND;
        else
            op = KIND_UNUSED;
        span = (cur_total > 4000) ? 400 : cur_total + 16;
        if ($urandom_range(99) < 85)
            cl = CLUSTER_W'($urandom_range(span));
        else
            cl = CLUSTER_W'($urandom);
        case ($urandom_range(9))
            0:       value = {4'($urandom), 28'h0};  // frees the entry
            1:       value = '1;
            2:       value = '0;
            default: value = $urandom;
        endcase
        send_item(op, cl, value);
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] first,
                                    input logic [CFG_DATA_W-1:0] total,
                                    input int idle, input int stall, input bit squeeze);
        configure(first, total);
        send_idle_pct = idle;
        stall_pct    <= stall;
        if (squeeze)
            squeeze_req <= 1'b1;
        repeat (PHASE_ITEMS) send_random_item();
        drain_results();
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [ENTRY_W-1:0] fill_value;

        rst_n              <= 1'b0;
        squeeze_req        <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_READ;
        req_ch.cluster     <= '0;
        req_ch.entry_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_FIRST_FAT_SECTOR;
        cfg_ch.data        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening on reset register values
        send_item(KIND_READ, 12'd0, '0);
        send_item(KIND_READ, 12'd4095, '0);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_WRITE, 12'd3, 32'hFFFF_FFFF);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_READ, 12'd3, '0);
        send_item(KIND_WRITE, 12'd0, 32'hF000_0000);
        send_item(KIND_WRITE, 12'd127, 32'h1234_5678);
        send_item(KIND_READ, 12'd128, '0);
        send_item(KIND_READ, 12'd127, '0);
        send_item(KIND_UNUSED, 12'd4095, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 12'd5, 32'hA5A5_A5A5);
        send_item(KIND_WRITE, 12'd6, 32'h5A5A_5A5A);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_WRITE, 12'd3, 32'hF000_0000);
        drain_results();

        // Hint already past the count, then an empty scan range
        configure(16'hFFFF, 16'd7);
        send_item(KIND_READ, 12'd4095, '0);
        send_item(KIND_FIND, 12'd0, '0);
        drain_results();
        configure(16'hFFFF, 16'd0);
        send_item(KIND_FIND, 12'hFFF, '1);
        drain_results();
        configure(16'd0, 16'd4096);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_READ, 12'd0, '0);
        drain_results();

        // Random phases over register settings and idle patterns
        run_random_phase(16'd0, 16'd64, 0, 0, 1'b0);
        run_random_phase(16'hFFFF, 16'd0, 51, 0, 1'b0);
        run_random_phase(16'($urandom), 16'd200, 0, 51, 1'b0);
        run_random_phase(16'd1000, 16'd4096, 0, 0, 1'b1);
        run_random_phase(16'($urandom), 16'd1, 14, 14, 1'b0);
        run_random_phase(16'($urandom), 16'($urandom_range(16, 512)), 0, 51, 1'b0);

        // Pull the hint down, then occupy the entries just above it
        configure(16'($urandom), 16'd0);
        send_idle_pct = 0;
        stall_pct    <= 0;
        send_item(KIND_FIND, 12'd0, '0);
        drain_results();
        for (int n = 1; n <= FILL_COUNT; n++)
        begin
            fill_value = $urandom;
            if (fill_value[VALUE_W-1:0] == '0)
                fill_value[0] = 1'b1;
            send_item(KIND_WRITE, CLUSTER_W'(n), fill_value);
        end
        drain_results();

        // Scan an occupied range with nothing free, then a bound past the table
        configure(16'($urandom), 16'(FILL_COUNT + 1));
        send_item(KIND_FIND, 12'd0, '0);
        drain_results();
        configure(16'($urandom), TOTAL_PAST_TABLE);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_READ, 12'd4095, '0);
        drain_results();
        configure(16'($urandom), 16'(ENTRIES));
        send_item(KIND_FIND, 12'd0, '0);
        drain_results();

        // Free two entries high in the table, then scan again from the bottom
        configure(16'($urandom), 16'd0);
        stall_pct <= 14;
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_WRITE, 12'd4000, 32'hF000_0000);
        send_item(KIND_WRITE, 12'd4095, 32'h3000_0000);
        drain_results();
        configure(16'($urandom), 16'(ENTRIES));
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_FIND, 12'd0, '0);
        send_item(KIND_READ, 12'd4000, '0);
        send_item(KIND_READ, 12'd2047, '0);
        drain_results();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
